[design/itaf_pkg.sv]
package itaf_pkg;

  // Format selector codes carried with each input beat.
  typedef enum logic [1:0] {
    FmtDec      = 2'd0,
    FmtHexLower = 2'd1,
    FmtHexUpper = 2'd2,
    FmtPointer  = 2'd3
  } fmt_e;

  // Fixed field widths of the channels.
  localparam int unsigned FuncW   = 2;
  localparam int unsigned InValW  = 64;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 5;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // ASCII codes used by the formatter.
  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharMinus  = 8'h2D;
  localparam logic [CharW-1:0] CharX      = 8'h78;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;

  // Maps one digit (0..15) to its ASCII character.
  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = CharZero + CharW'(d);
    end else if (upper) begin
      c = CharUpperA + CharW'(d - 4'd10);
    end else begin
      c = CharLowerA + CharW'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

[design/itaf_if.sv]
// Input channel: one value and its format per beat.
interface itaf_in_if;
  import itaf_pkg::*;
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [InValW-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

// Output channel: one character per beat.
interface itaf_out_if;
  import itaf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CharW-1:0]  ascii_char;
  logic              last;
  logic [CountW-1:0] char_count;

  modport source (output valid, ascii_char, last, char_count, input ready);
  modport sink   (input valid, ascii_char, last, char_count, output ready);
endinterface

[design/itaf_front.sv]
module itaf_front import itaf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned DataW      = FuncW + 1 + VALUE_BITS
) (
  itaf_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output logic [DataW-1:0] data_o
);

  logic [VALUE_BITS-1:0] val;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  // Take a beat whenever the queue has room.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Keep the used bits, and turn a negative decimal value into sign and magnitude.
  assign val = in_i.value[VALUE_BITS-1:0];
  assign neg = (fmt_e'(in_i.func) == FmtDec) && val[VALUE_BITS-1];
  assign mag = neg ? (~val + VALUE_BITS'(1)) : val;

  assign data_o = {in_i.func, neg, mag};

endmodule

[design/itaf_fifo.sv]
module itaf_fifo import itaf_pkg::*; #(
  parameter int unsigned DataW = 67
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [DataW-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage for the queued items.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CntW'(QueueDepth)))
    else $error("Queue written while full.");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("Queue read while empty.");
`endif

endmodule

[design/itaf_back.sv]
module itaf_back import itaf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [FuncW-1:0]      func_i,
  input  logic                  neg_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  output logic                  pop_o,
  itaf_out_if.source            out_o
);

  localparam int unsigned DecDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned HexDigits = (VALUE_BITS + 3) / 4;
  localparam int unsigned DigW      = DecDigits * 4;
  localparam int unsigned HexW      = HexDigits * 4;
  localparam int unsigned NdigW     = $clog2(DecDigits + 1);
  localparam int unsigned BitCntW   = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StConv   = 5'b00010,
    StSkip   = 5'b00100,
    StPrefix = 5'b01000,
    StDigits = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  fmt_e                  fmt_q, fmt_d;
  logic                  neg_q, neg_d;
  logic [DigW-1:0]       dig_q, dig_d;
  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [NdigW-1:0]      ndig_q, ndig_d;
  logic [1:0]            pre_q, pre_d;
  logic [CountW-1:0]     len_q, len_d;

  logic                  ovalid_q, ovalid_d;
  logic [CharW-1:0]      char_q, char_d;
  logic                  last_q, last_d;
  logic [CountW-1:0]     count_q, count_d;

  logic                  slot_free;
  logic [3:0]            top_dig;
  logic [DigW-1:0]       bcd_adj;
  logic [1:0]            pre_len;

  assign slot_free = !ovalid_q || out_o.ready;
  assign top_dig   = dig_q[DigW-1 -: 4];
  assign pop_o     = (state_q == StIdle) && valid_i;

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      bcd_adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3
                                                    : dig_q[i*4 +: 4];
    end
  end

  // Number of characters in front of the digits.
  always_comb begin
    if (fmt_q == FmtPointer) begin
      pre_len = 2'd2;
    end else if (fmt_q == FmtDec && neg_q) begin
      pre_len = 2'd1;
    end else begin
      pre_len = 2'd0;
    end
  end

  // Conversion and emission sequencer.
  always_comb begin
    state_d   = state_q;
    fmt_d     = fmt_q;
    neg_d     = neg_q;
    dig_d     = dig_q;
    sh_d      = sh_q;
    bit_cnt_d = bit_cnt_q;
    ndig_d    = ndig_q;
    pre_d     = pre_q;
    len_d     = len_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    char_d    = char_q;
    last_d    = last_q;
    count_d   = count_q;

    unique case (state_q)
      StIdle: begin
        if (valid_i) begin
          fmt_d = fmt_e'(func_i);
          neg_d = neg_i;
          if (fmt_e'(func_i) == FmtDec) begin
            dig_d     = '0;
            sh_d      = mag_i;
            bit_cnt_d = BitCntW'(VALUE_BITS);
            state_d   = StConv;
          end else begin
            dig_d   = {HexW'(mag_i), (DigW - HexW)'(0)};
            ndig_d  = NdigW'(HexDigits);
            state_d = StSkip;
          end
        end
      end
      StConv: begin
        dig_d     = {bcd_adj[DigW-2:0], sh_q[VALUE_BITS-1]};
        sh_d      = {sh_q[VALUE_BITS-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BitCntW'(1);
        if (bit_cnt_q == BitCntW'(1)) begin
          ndig_d  = NdigW'(DecDigits);
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Drop leading zero digits, keeping at least one.
        if (top_dig == 4'd0 && ndig_q != NdigW'(1)) begin
          dig_d  = {dig_q[DigW-5:0], 4'd0};
          ndig_d = ndig_q - NdigW'(1);
        end else begin
          len_d   = CountW'(pre_len) + CountW'(ndig_q);
          pre_d   = pre_len;
          state_d = (pre_len != 2'd0) ? StPrefix : StDigits;
        end
      end
      StPrefix: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          last_d   = 1'b0;
          count_d  = '0;
          if (fmt_q == FmtDec) begin
            char_d = CharMinus;
          end else if (pre_q == 2'd2) begin
            char_d = CharZero;
          end else begin
            char_d = CharX;
          end
          pre_d = pre_q - 2'd1;
          if (pre_q == 2'd1) begin
            state_d = StDigits;
          end
        end
      end
      StDigits: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          char_d   = digit_char(top_dig, fmt_q == FmtHexUpper);
          last_d   = (ndig_q == NdigW'(1));
          count_d  = (ndig_q == NdigW'(1)) ? len_q : '0;
          dig_d    = {dig_q[DigW-5:0], 4'd0};
          ndig_d   = ndig_q - NdigW'(1);
          if (ndig_q == NdigW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    fmt_q     <= fmt_d;
    neg_q     <= neg_d;
    dig_q     <= dig_d;
    sh_q      <= sh_d;
    bit_cnt_q <= bit_cnt_d;
    ndig_q    <= ndig_d;
    pre_q     <= pre_d;
    len_q     <= len_d;
    char_q    <= char_d;
    last_q    <= last_d;
    count_q   <= count_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.ascii_char = char_q;
  assign out_o.last       = last_q;
  assign out_o.char_count = count_q;

`ifndef NO_ASSERTIONS
  a_last_has_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && last_q) |-> (count_q != '0))
    else $error("Final character without a character count.");
  a_mid_no_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !last_q) |-> (count_q == '0))
    else $error("Character count on a character that is not the last.");
  a_digits_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDigits || state_q == StSkip) |-> (ndig_q != '0))
    else $error("Digit phase entered with no digits left.");
  a_no_pop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !pop_o)
    else $error("Item taken from the queue while a conversion is running.");
`endif

endmodule

[design/integer_to_ascii_formatter_unit.sv]
// Integer to ASCII formatter. Each input beat carries a value and a format
// (signed decimal, lower-case hex, upper-case hex, or pointer "0x" + lower-case
// hex); the unit returns the text one character per output beat, most
// significant first, with last and the total character count on the final
// beat. Only the low VALUE_BITS bits of the value are used. A front stage
// takes sign and magnitude and places the item into a two-entry queue; the
// back end converts one item at a time. It takes an item from the queue; a
// decimal item then passes through the bit-serial BCD converter (one
// shift-and-adjust per cycle); then leading zero digits are dropped, the text
// is sized, and each character is emitted and held until the sink takes it.
module integer_to_ascii_formatter_unit import itaf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itaf_in_if.sink     in_i,
  itaf_out_if.source  out_o
);

  localparam int unsigned DataW = FuncW + 1 + VALUE_BITS;

  logic             push;
  logic             full;
  logic [DataW-1:0] wr_data;
  logic             pop;
  logic             q_valid;
  logic [DataW-1:0] rd_data;

  itaf_front #(
    .VALUE_BITS (VALUE_BITS),
    .DataW      (DataW)
  ) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .data_o (wr_data)
  );

  itaf_fifo #(
    .DataW (DataW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (rd_data)
  );

  itaf_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .func_i  (rd_data[DataW-1 -: FuncW]),
    .neg_i   (rd_data[VALUE_BITS]),
    .mag_i   (rd_data[VALUE_BITS-1:0]),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
